[design/chip8_instruction_core_macros.svh]
// Assertion macros shared by the CHIP-8 instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define C8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chip8 core check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define C8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chip8 core check failed");

`endif

[design/chip8_pkg.sv]
// Constants, codes and the font table of the CHIP-8 instruction core.
package chip8_pkg;

  localparam int MEM_BYTES  = 4096;
  localparam int MEM_AW     = 12;
  localparam int SCREEN_W   = 64;
  localparam int SCREEN_H   = 32;
  localparam int FB_AW      = 5;
  localparam int FONT_BYTES = 80;

  localparam logic [11:0] START_RESET = 12'h200;
  localparam logic [2:0]  REG_START_ADDRESS = 3'd0;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNIMPL = 2'd1;
  localparam logic [1:0] ST_STACK  = 2'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_ROW   = 2'd2;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] SER_TAIL = 4'h0;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] F_GET_DT = 8'h07;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I  = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_LOAD   = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (addr < MEM_AW'(FONT_BYTES)) b = FONT[addr[6:0]];
    return b;
  endfunction

endpackage

[design/chip8_instruction_core.sv]
// Top level of the CHIP-8 instruction core: sequencer around program, register and display memories.
//
// Requests enter on start/busy: one is taken at a rising edge with start high and busy low.
// mode 0 writes one program memory byte, mode 1 fetches and executes one instruction and
// then, if it completes without fault, ticks both timers down, mode 2 reads one 64-pixel display row.
// Each request gives one result, shown for one cycle with done_o; the receiver cannot stall.
// Modes 0 and 3 go straight to the result and mode 2 reads the row first; instructions
// pass fetch, decode and execute, with added states for two-write ALU ops, return, BCD,
// Fx65 (one memory read and one register write per loaded register) and Dxyn (one display
// row read and written per sprite row); requests run one at a time.
// start_address sits on an APB-style port at byte address 0; writing it also loads the
// program counter. Write it only while no request is in flight.
// After reset the core loads the font and clears program memory,
// with busy high; configuration writes are taken during that time.
`include "chip8_instruction_core_macros.svh"

module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] keys_i,
  input  logic [7:0]  random_byte_i,
  input  logic [4:0]  row_i,
  output logic        done_o,
  output logic [11:0] program_counter_o,
  output logic [15:0] opcode_o,
  output logic        drew_o,
  output logic [1:0]  status_o,
  output logic        sound_on_o,
  output logic [63:0] row_pixels_o
);
  import chip8_pkg::*;

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int StW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR, S_SETTLE, S_IDLE, S_FETCH_LO, S_DECODE_X, S_DECODE_Y, S_EXEC, S_RET,
    S_WVF, S_DRAW_RD, S_DRAW_WR, S_DRAW_END, S_BCD1, S_BCD2, S_LOAD_RD, S_LOAD_WR,
    S_ROW, S_DONE
  } state_e;

  state_e state_q;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  vmem [16];
  logic [63:0] fbmem [SCREEN_H];
  logic [11:0] stk [STACK_DEPTH];

  logic              mem_we_q;
  logic [MEM_AW-1:0] mem_waddr_q;
  logic [7:0]        mem_wdata_q;
  logic [MEM_AW-1:0] mem_raddr;
  logic [7:0]        mem_rdata_q;

  logic       v_we_q;
  logic [3:0] v_waddr_q;
  logic [7:0] v_wdata_q;
  logic [3:0] v_raddr;
  logic [7:0] v_rdata_q;
  logic       v_rvalid_q;
  logic [15:0] v_valid_q;
  logic [7:0] v_cur;

  logic             fb_we_q;
  logic [FB_AW-1:0] fb_waddr_q;
  logic [63:0]      fb_wdata_q;
  logic [FB_AW-1:0] fb_raddr;
  logic [63:0]      fb_rdata_q;
  logic             fb_rvalid_q;
  logic [SCREEN_H-1:0] fb_valid_q;
  logic [SCREEN_H-1:0] fb_nz_q;
  logic [63:0]      fb_cur;

  logic           stk_we_q;
  logic [StW-1:0] stk_waddr_q;
  logic [11:0]    stk_wdata_q;
  logic [StW-1:0] stk_raddr;
  logic [11:0]    stk_rdata_q;

  logic [11:0] start_q, pc_q, npc_q, clr_q;
  logic [15:0] op_q, idx_q;
  logic [7:0]  vx_q, dt_q, st_q, bcd_t_q, bcd_o_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;
  logic [SpW-1:0] sp_q;
  logic [1:0]  status_q;
  logic        drew_q, exec_q, coll_q, chg_q;
  logic [63:0] pix_q;
  logic [3:0]  cnt_q, n_q;
  logic [5:0]  x0_q;
  logic [4:0]  y0_q;

  logic [11:0] pc_inc;
  logic [7:0]  kk;
  logic [3:0]  rx;
  logic [8:0]  add9;
  logic [7:0]  rev;
  logic [127:0] rot_full;
  logic [63:0] mask;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic        key_down, cfg_wr, commit;
  logic [11:0] fin_pc;

  assign busy   = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_START_ADDRESS) ? {20'b0, start_q} : 32'b0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_START_ADDRESS);

  assign v_cur  = v_rvalid_q ? v_rdata_q : 8'h00;
  assign fb_cur = fb_rvalid_q ? fb_rdata_q : 64'b0;
  assign pc_inc = pc_q + 12'd2;
  assign kk     = op_q[7:0];
  assign rx     = op_q[11:8];
  assign add9   = {1'b0, vx_q} + {1'b0, v_cur};
  assign key_down = keys_q[vx_q[3:0]];

  always_comb begin
    for (int c = 0; c < 8; c++) rev[c] = mem_rdata_q[7-c];
    rot_full = {56'b0, rev, 56'b0, rev} << x0_q;
    mask     = rot_full[127:64];
  end

  always_comb begin
    if (vx_q >= 8'd200) bcd_h = 2'd2;
    else if (vx_q >= 8'd100) bcd_h = 2'd1;
    else bcd_h = 2'd0;
    bcd_rem  = vx_q - ((bcd_h == 2'd2) ? 8'd200 : (bcd_h == 2'd1) ? 8'd100 : 8'd0);
    bcd_prod = 15'(bcd_rem[6:0]) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - 8'(bcd_t) * 8'd10;
  end

  always_comb begin
    case (state_q)
      S_FETCH_LO:           mem_raddr = pc_q + 12'd1;
      S_DRAW_RD, S_LOAD_RD: mem_raddr = idx_q[11:0] + {8'b0, cnt_q};
      default:              mem_raddr = pc_q;
    endcase
    case (state_q)
      S_DRAW_RD: fb_raddr = y0_q + {1'b0, cnt_q};
      default:   fb_raddr = row_i;
    endcase
    case (state_q)
      S_DECODE_X: v_raddr = op_q[11:8];
      default:    v_raddr = op_q[7:4];
    endcase
    stk_raddr = StW'(sp_q - SpW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_q) mem[mem_waddr_q] <= mem_wdata_q;
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (v_we_q) vmem[v_waddr_q] <= v_wdata_q;
    v_rdata_q  <= vmem[v_raddr];
    v_rvalid_q <= v_valid_q[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fb_we_q) fbmem[fb_waddr_q] <= fb_wdata_q;
    fb_rdata_q  <= fbmem[fb_raddr];
    fb_rvalid_q <= fb_valid_q[fb_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we_q) stk[stk_waddr_q] <= stk_wdata_q;
    stk_rdata_q <= stk[stk_raddr];
  end

  assign commit = exec_q && (status_q == ST_OK);
  assign fin_pc = commit ? npc_q : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mem_we_q <= 1'b0; mem_waddr_q <= '0; mem_wdata_q <= '0;
      v_we_q <= 1'b0; v_waddr_q <= '0; v_wdata_q <= '0; v_valid_q <= '0;
      fb_we_q <= 1'b0; fb_waddr_q <= '0; fb_wdata_q <= '0;
      fb_valid_q <= '0; fb_nz_q <= '0;
      stk_we_q <= 1'b0; stk_waddr_q <= '0; stk_wdata_q <= '0;
      start_q <= START_RESET; pc_q <= START_RESET; npc_q <= '0; clr_q <= '0;
      op_q <= '0; idx_q <= '0; vx_q <= '0; dt_q <= '0; st_q <= '0;
      keys_q <= '0; rnd_q <= '0;
      bcd_t_q <= '0; bcd_o_q <= '0; sp_q <= '0;
      status_q <= ST_OK; drew_q <= 1'b0; exec_q <= 1'b0; coll_q <= 1'b0; chg_q <= 1'b0;
      pix_q <= '0; cnt_q <= '0; n_q <= '0; x0_q <= '0; y0_q <= '0;
      done_o <= 1'b0; program_counter_o <= '0; opcode_o <= '0; drew_o <= 1'b0;
      status_o <= ST_OK; sound_on_o <= 1'b0; row_pixels_o <= '0;
    end else begin
      mem_we_q <= 1'b0;
      v_we_q   <= 1'b0;
      fb_we_q  <= 1'b0;
      stk_we_q <= 1'b0;
      done_o   <= 1'b0;
      if (v_we_q) v_valid_q[v_waddr_q] <= 1'b1;
      if (fb_we_q) begin
        fb_valid_q[fb_waddr_q] <= 1'b1;
        fb_nz_q[fb_waddr_q]    <= |fb_wdata_q;
      end
      if (cfg_wr) begin
        start_q <= pwdata[11:0];
        pc_q    <= pwdata[11:0];
      end
      case (state_q)
        S_CLEAR: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= clr_q;
          mem_wdata_q <= font_byte(clr_q);
          clr_q       <= clr_q + 12'd1;
          if (clr_q == 12'hFFF) state_q <= S_SETTLE;
        end
        S_SETTLE: state_q <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            status_q <= ST_OK;
            drew_q   <= 1'b0;
            exec_q   <= 1'b0;
            pix_q    <= '0;
            keys_q   <= keys_i;
            rnd_q    <= random_byte_i;
            case (mode_i)
              MODE_WRITE: begin
                mem_we_q    <= 1'b1;
                mem_waddr_q <= address_i;
                mem_wdata_q <= data_byte_i;
                state_q     <= S_DONE;
              end
              MODE_EXEC: begin
                exec_q  <= 1'b1;
                state_q <= S_FETCH_LO;
              end
              MODE_ROW: state_q <= S_ROW;
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_ROW: begin
          pix_q   <= fb_cur;
          state_q <= S_DONE;
        end
        S_FETCH_LO: begin
          op_q[15:8] <= mem_rdata_q;
          state_q    <= S_DECODE_X;
        end
        S_DECODE_X: begin
          op_q[7:0] <= mem_rdata_q;
          state_q   <= S_DECODE_Y;
        end
        S_DECODE_Y: begin
          vx_q    <= v_cur;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          npc_q   <= pc_inc;
          state_q <= S_DONE;
          case (op_q[15:12])
            OP_SYS: begin
              if (op_q == OPC_CLS) begin
                drew_q     <= |fb_nz_q;
                fb_valid_q <= '0;
                fb_nz_q    <= '0;
              end else if (op_q == OPC_RET) begin
                if (sp_q == '0) status_q <= ST_STACK;
                else state_q <= S_RET;
              end
            end
            OP_JP: npc_q <= op_q[11:0];
            OP_CALL: begin
              if (sp_q >= SpW'(STACK_DEPTH)) begin
                status_q <= ST_STACK;
              end else begin
                stk_we_q    <= 1'b1;
                stk_waddr_q <= sp_q[StW-1:0];
                stk_wdata_q <= pc_inc;
                sp_q        <= sp_q + SpW'(1);
                npc_q       <= op_q[11:0];
              end
            end
            OP_SE:  if (vx_q == kk) npc_q <= pc_inc + 12'd2;
            OP_SNE: if (vx_q != kk) npc_q <= pc_inc + 12'd2;
            OP_SER: begin
              if (op_q[3:0] != SER_TAIL) status_q <= ST_UNIMPL;
              else if (vx_q == v_cur) npc_q <= pc_inc + 12'd2;
            end
            OP_LD: begin
              v_we_q <= 1'b1; v_waddr_q <= rx; v_wdata_q <= kk;
            end
            OP_ADD: begin
              v_we_q <= 1'b1; v_waddr_q <= rx; v_wdata_q <= vx_q + kk;
            end
            OP_ALU: begin
              v_waddr_q <= rx;
              case (op_q[3:0])
                ALU_MOV: begin v_we_q <= 1'b1; v_wdata_q <= v_cur; end
                ALU_OR:  begin v_we_q <= 1'b1; v_wdata_q <= vx_q | v_cur; end
                ALU_AND: begin v_we_q <= 1'b1; v_wdata_q <= vx_q & v_cur; end
                ALU_XOR: begin v_we_q <= 1'b1; v_wdata_q <= vx_q ^ v_cur; end
                ALU_ADD: begin
                  v_we_q <= 1'b1; v_wdata_q <= add9[7:0];
                  coll_q <= add9[8]; state_q <= S_WVF;
                end
                ALU_SUB: begin
                  v_we_q <= 1'b1; v_wdata_q <= vx_q - v_cur;
                  coll_q <= (vx_q > v_cur); state_q <= S_WVF;
                end
                default: status_q <= ST_UNIMPL;
              endcase
            end
            OP_LDI: idx_q <= {4'b0, op_q[11:0]};
            OP_RND: begin
              v_we_q <= 1'b1; v_waddr_q <= rx; v_wdata_q <= rnd_q & kk;
            end
            OP_DRW: begin
              v_we_q <= 1'b1; v_waddr_q <= REG_VF; v_wdata_q <= 8'h00;
              x0_q   <= vx_q[5:0];
              y0_q   <= v_cur[4:0];
              n_q    <= op_q[3:0];
              cnt_q  <= '0;
              coll_q <= 1'b0;
              chg_q  <= 1'b0;
              state_q <= (op_q[3:0] == 4'd0) ? S_DRAW_END : S_DRAW_RD;
            end
            OP_KEY: begin
              if (kk == KEY_DOWN) begin
                if (key_down) npc_q <= pc_inc + 12'd2;
              end else if (kk == KEY_UP) begin
                if (!key_down) npc_q <= pc_inc + 12'd2;
              end else begin
                status_q <= ST_UNIMPL;
              end
            end
            OP_MISC: begin
              case (kk)
                F_GET_DT: begin
                  v_we_q <= 1'b1; v_waddr_q <= rx; v_wdata_q <= dt_q;
                end
                F_SET_DT: dt_q <= vx_q;
                F_SET_ST: st_q <= vx_q;
                F_ADD_I:  idx_q <= idx_q + {8'b0, vx_q};
                F_FONT:   idx_q <= {8'b0, vx_q} * 16'd5;
                F_BCD: begin
                  mem_we_q    <= 1'b1;
                  mem_waddr_q <= idx_q[11:0];
                  mem_wdata_q <= {6'b0, bcd_h};
                  bcd_t_q     <= {4'b0, bcd_t};
                  bcd_o_q     <= bcd_o;
                  state_q     <= S_BCD1;
                end
                F_LOAD: begin
                  n_q     <= rx;
                  cnt_q   <= '0;
                  state_q <= S_LOAD_RD;
                end
                default: status_q <= ST_UNIMPL;
              endcase
            end
            default: status_q <= ST_UNIMPL;
          endcase
        end
        S_RET: begin
          npc_q   <= stk_rdata_q;
          sp_q    <= sp_q - SpW'(1);
          state_q <= S_DONE;
        end
        S_WVF: begin
          v_we_q <= 1'b1; v_waddr_q <= REG_VF; v_wdata_q <= {7'b0, coll_q};
          state_q <= S_DONE;
        end
        S_DRAW_RD: state_q <= S_DRAW_WR;
        S_DRAW_WR: begin
          fb_we_q    <= 1'b1;
          fb_waddr_q <= y0_q + {1'b0, cnt_q};
          fb_wdata_q <= fb_cur ^ mask;
          if (|(fb_cur & mask)) coll_q <= 1'b1;
          if (|mask) chg_q <= 1'b1;
          cnt_q <= cnt_q + 4'd1;
          state_q <= (cnt_q == n_q - 4'd1) ? S_DRAW_END : S_DRAW_RD;
        end
        S_DRAW_END: begin
          if (coll_q) begin
            v_we_q <= 1'b1; v_waddr_q <= REG_VF; v_wdata_q <= 8'h01;
          end
          drew_q  <= chg_q;
          state_q <= S_DONE;
        end
        S_BCD1: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= idx_q[11:0] + 12'd1;
          mem_wdata_q <= bcd_t_q;
          state_q     <= S_BCD2;
        end
        S_BCD2: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= idx_q[11:0] + 12'd2;
          mem_wdata_q <= bcd_o_q;
          state_q     <= S_DONE;
        end
        S_LOAD_RD: state_q <= S_LOAD_WR;
        S_LOAD_WR: begin
          v_we_q <= 1'b1; v_waddr_q <= cnt_q; v_wdata_q <= mem_rdata_q;
          cnt_q  <= cnt_q + 4'd1;
          state_q <= (cnt_q == n_q) ? S_DONE : S_LOAD_RD;
        end
        S_DONE: begin
          if (commit) begin
            pc_q <= npc_q;
            if (dt_q != 8'h00) dt_q <= dt_q - 8'h01;
            if (st_q != 8'h00) st_q <= st_q - 8'h01;
          end
          done_o            <= 1'b1;
          program_counter_o <= fin_pc;
          opcode_o          <= exec_q ? op_q : 16'h0000;
          drew_o            <= drew_q;
          status_o          <= status_q;
          sound_on_o        <= commit ? (st_q > 8'h01) : (st_q != 8'h00);
          row_pixels_o      <= pix_q;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `C8_ASSERT_NXT(a_done_pulse, done_o, !done_o)
  `C8_ASSERT_IMP(a_sp_range, 1'b1, sp_q <= SpW'(STACK_DEPTH))
  `C8_ASSERT_IMP(a_fault_quiet, done_o && status_o != ST_OK, !drew_o)
  `C8_ASSERT_IMP(a_clear_busy, state_q == S_CLEAR, busy && !done_o)

endmodule
